### src/cit_pkg.sv
// shared types and codes for the counted item table
package cit_pkg;

  localparam int unsigned CIT_CAPACITY = 16;

  localparam int unsigned KEY_W    = 8;
  localparam int unsigned PRICE_W  = 16;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned CSLOT_W  = 4;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned FILLED_W = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic {
    FUNC_ADD    = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    STATUS_NEW       = 3'd0,
    STATUS_INC       = 3'd1,
    STATUS_DEC       = 3'd2,
    STATUS_DEL       = 3'd3,
    STATUS_NOT_FOUND = 3'd4,
    STATUS_FULL      = 3'd5,
    STATUS_SAT       = 3'd6
  } status_e;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [PRICE_W-1:0] price;
    logic [COUNT_W-1:0] count;
    logic [CSLOT_W-1:0] cslot;
  } entry_t;

endpackage

### src/counted_item_table.sv
// counted item table: compact key table with counts, scanned by a sequencer
//
// Each word asks to add or remove one of an item. The block scans the filled
// entries of a table memory (one write port, one registered read port) from
// position 0, reading and then comparing each entry until the key is hit or
// the fill level is reached. A delete then moves each later entry down one
// position, each moved entry read and then written back, keeping the entries
// packed at positions 0 .. fill-1. s_axis_tready is high only while the block
// is idle, and the result word waits in the output register until taken.
// No clearing pass is needed after reset: only filled entries are read.
module counted_item_table #(
  parameter int unsigned CAPACITY = cit_pkg::CIT_CAPACITY
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // item_key[7:0], item_price[23:8], catalog_slot[27:24], zero fill
  input  logic [31:0] s_axis_tdata,
  // func
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // entry_slot[3:0], item_count[11:4], filled_entries[16:12], zero fill
  output logic [23:0] m_axis_tdata,
  // status
  output logic [2:0]  m_axis_tuser
);
  import cit_pkg::*;

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned FW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_HIT,
    S_MISS,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_OUT
  } state_e;

  state_e               state_q;
  logic [IW-1:0]        idx_q;
  logic [FW-1:0]        fill_q;
  func_e                func_q;
  logic [KEY_W-1:0]     key_q;
  logic [PRICE_W-1:0]   price_q;
  logic [CSLOT_W-1:0]   cslot_q;
  status_e              status_q;
  logic [SLOT_W-1:0]    slot_q;
  logic [COUNT_W-1:0]   count_q;

  entry_t               mem [CAPACITY];
  entry_t               rd_q;
  logic [IW-1:0]        rd_addr;
  logic                 mem_we;
  logic [IW-1:0]        mem_waddr;
  entry_t               mem_wdata;

  logic                 full;
  logic [FW-1:0]        idx_ext;
  logic [FW:0]          idx_plus2;
  logic                 in_acc;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign full      = (fill_q == FW'(CAPACITY));
  assign idx_ext   = FW'(idx_q);
  assign idx_plus2 = {1'b0, idx_ext} + (FW+1)'(2);

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {7'd0, FILLED_W'(fill_q), count_q, slot_q};

  // table memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = rd_q;
    rd_addr   = idx_q;
    unique case (state_q)
      S_HIT: begin
        if (func_q == FUNC_ADD) begin
          if (rd_q.count != COUNT_MAX) begin
            mem_we          = 1'b1;
            mem_wdata.count = rd_q.count + COUNT_W'(1);
          end
        end else if (rd_q.count > COUNT_W'(1)) begin
          mem_we          = 1'b1;
          mem_wdata.count = rd_q.count - COUNT_W'(1);
        end
      end
      S_MISS: begin
        if (func_q == FUNC_ADD && !full) begin
          mem_we          = 1'b1;
          mem_waddr       = fill_q[IW-1:0];
          mem_wdata.key   = key_q;
          mem_wdata.price = price_q;
          mem_wdata.count = COUNT_W'(1);
          mem_wdata.cslot = cslot_q;
        end
      end
      S_SHIFT_RD: begin
        rd_addr = idx_q + IW'(1);
      end
      S_SHIFT_WR: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      fill_q   <= '0;
      func_q   <= FUNC_ADD;
      key_q    <= '0;
      price_q  <= '0;
      cslot_q  <= '0;
      status_q <= STATUS_NEW;
      slot_q   <= '0;
      count_q  <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            func_q  <= func_e'(s_axis_tuser);
            key_q   <= s_axis_tdata[7:0];
            price_q <= s_axis_tdata[23:8];
            cslot_q <= s_axis_tdata[27:24];
            idx_q   <= '0;
            state_q <= (fill_q == '0) ? S_MISS : S_READ;
          end
        end
        S_READ: begin
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (rd_q.key == key_q) begin
            state_q <= S_HIT;
          end else if (idx_ext + FW'(1) == fill_q) begin
            state_q <= S_MISS;
          end else begin
            idx_q   <= idx_q + IW'(1);
            state_q <= S_READ;
          end
        end
        S_HIT: begin
          slot_q <= SLOT_W'(idx_q);
          if (func_q == FUNC_ADD) begin
            if (rd_q.count == COUNT_MAX) begin
              status_q <= STATUS_SAT;
              count_q  <= COUNT_MAX;
            end else begin
              status_q <= STATUS_INC;
              count_q  <= rd_q.count + COUNT_W'(1);
            end
            state_q <= S_OUT;
          end else if (rd_q.count > COUNT_W'(1)) begin
            status_q <= STATUS_DEC;
            count_q  <= rd_q.count - COUNT_W'(1);
            state_q  <= S_OUT;
          end else begin
            status_q <= STATUS_DEL;
            count_q  <= '0;
            // entries above the deleted one move down
            if (idx_ext + FW'(1) < fill_q) begin
              state_q <= S_SHIFT_RD;
            end else begin
              fill_q  <= fill_q - FW'(1);
              state_q <= S_OUT;
            end
          end
        end
        S_MISS: begin
          if (func_q == FUNC_REMOVE) begin
            status_q <= STATUS_NOT_FOUND;
            slot_q   <= '0;
            count_q  <= '0;
          end else if (full) begin
            status_q <= STATUS_FULL;
            slot_q   <= '0;
            count_q  <= '0;
          end else begin
            status_q <= STATUS_NEW;
            slot_q   <= SLOT_W'(fill_q);
            count_q  <= COUNT_W'(1);
            fill_q   <= fill_q + FW'(1);
          end
          state_q <= S_OUT;
        end
        S_SHIFT_RD: begin
          state_q <= S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          idx_q <= idx_q + IW'(1);
          if (idx_plus2 < {1'b0, fill_q}) begin
            state_q <= S_SHIFT_RD;
          end else begin
            fill_q  <= fill_q - FW'(1);
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_axis_tready) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule
